// ----- sv/i2cem_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cem_pkg
// Shared types, codes and constants of the I2C memory-device master sequencer.
// ----------------------------------------------------------------------------
package i2cem_pkg;

	localparam int BUF_LEN_DEF = 64;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_EVENT = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_BUSY = 2'd2;

	localparam logic [2:0] CMD_NONE    = 3'd0;
	localparam logic [2:0] CMD_START   = 3'd1;
	localparam logic [2:0] CMD_RESTART = 3'd2;
	localparam logic [2:0] CMD_STOP    = 3'd3;
	localparam logic [2:0] CMD_SEND    = 3'd4;
	localparam logic [2:0] CMD_RECV    = 3'd5;
	localparam logic [2:0] CMD_ACK     = 3'd6;
	localparam logic [2:0] CMD_NACK    = 3'd7;

	localparam logic [2:0] REG_PAGE_SIZE  = 3'd0;
	localparam logic [2:0] REG_NACK_LIMIT = 3'd4;

	localparam logic [8:0] PAGE_SIZE_RST  = 9'd64;
	localparam logic [7:0] NACK_LIMIT_RST = 8'd0;

	localparam logic [7:0] DEV_ADDR_MASK = 8'hfe;
	localparam logic [7:0] DEV_RD_BIT    = 8'h01;
	localparam logic [7:0] NACK_SAT      = 8'hff;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  data_byte;
		logic [7:0]  device_addr;
		logic [15:0] mem_addr;
		logic [6:0]  read_count;
		logic        ack_stat;
		logic        bus_collision;
		logic [7:0]  rx_byte;
	} item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [2:0] bus_cmd;
		logic [7:0] send_byte;
		logic       rx_valid;
		logic [5:0] rx_index;
		logic [7:0] rx_data;
		logic       write_done;
		logic       read_done;
		logic       failed;
	} result_t;

endpackage

// ----- sv/i2c_eeprom_master_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// i2c_eeprom_master_sequencer_core
// Byte-level I2C master sequencer for 16-bit-addressed memory devices.
// ----------------------------------------------------------------------------
// Input channel (item_valid/item_stall/item): buffer loads, write and read
// requests, and bus-completion events carrying ack, collision and rx byte.
// Output channel (result_valid/result_stall/result): exactly one result word
// per input word, in order: status, next bus command, byte to send, stored
// received byte and done/failed flags.
// Registers on the APB port: page_size at 0x0, nack_limit at 0x4; write only
// while the sequencer is idle. pready is tied high.
// An accepted word passes the RAM-read stage, then the output register.
// Throughput: one word per cycle unless the receiver stalls. The byte buffer
// for transmit and receive is a single-port RAM read in the accept cycle and
// registered, merged into the result in the RAM-read stage, then held in the
// output register. While the receiver stalls, the output register holds and
// one more word is taken into the RAM-read stage; item_stall then rises until
// the output drains. Reset clears all control state and sets the registers
// to 64 and 0; the buffer RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module i2c_eeprom_master_sequencer_core #(
	parameter int BUF_LEN = i2cem_pkg::BUF_LEN_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  i2cem_pkg::item_t  item,
	output logic              result_valid,
	input  logic              result_stall,
	output i2cem_pkg::result_t result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import i2cem_pkg::*;

	localparam int IDX_W = (BUF_LEN > 1) ? $clog2(BUF_LEN) : 1;
	localparam int CNT_W = $clog2(BUF_LEN + 1);
	localparam int PE_W  = $clog2(BUF_LEN + 257);
	localparam logic [8:0]       BUF_LEN_9 = 9'(BUF_LEN);
	localparam logic [CNT_W-1:0] BUF_FULL  = CNT_W'(BUF_LEN);

	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_START   = 3'd1;
	localparam logic [2:0] PH_STOP    = 3'd2;
	localparam logic [2:0] PH_RESTART = 3'd3;
	localparam logic [2:0] PH_ACKWAIT = 3'd4;
	localparam logic [2:0] PH_RECV    = 3'd5;
	localparam logic [2:0] PH_ACKSENT = 3'd6;
	localparam logic [2:0] PH_NACKSENT = 3'd7;

	logic [8:0] page_size_q;
	logic [7:0] nack_limit_q;

	logic [2:0]       phase_q, phase_d;
	logic             is_write_q, is_write_d;
	logic             polling_q, polling_d;
	logic             restarted_q, restarted_d;
	logic             hi_q, hi_d;
	logic             lo_q, lo_d;
	logic             fail_q, fail_d;
	logic [7:0]       dev_q, dev_d;
	logic [15:0]      maddr_q, maddr_d;
	logic [CNT_W-1:0] tx_fill_q, tx_fill_d;
	logic [CNT_W-1:0] buf_pos_q, buf_pos_d;
	logic [PE_W-1:0]  page_end_q, page_end_d;
	logic [CNT_W-1:0] rx_total_q, rx_total_d;
	logic [7:0]       nack_q, nack_d;

	logic [7:0]       mem [BUF_LEN];
	logic [7:0]       rdata_q;
	logic             mem_we, mem_re;
	logic [IDX_W-1:0] mem_addr;
	logic [7:0]       mem_wdata;

	logic    accept, advance;
	logic    v_s1, mem_sel_s1, mem_sel;
	result_t res_s1, res;
	result_t merged_s1;
	logic    out_v_q;
	result_t out_q;

	logic [8:0]      ps, n9, bp9;
	logic [PE_W-1:0] ps_pe;
	logic [7:0]      nack_inc;
	logic [CNT_W-1:0] bp_inc;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_size_q  <= PAGE_SIZE_RST;
			nack_limit_q <= NACK_LIMIT_RST;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_NACK_LIMIT[2]) begin
				nack_limit_q <= pwdata[7:0];
			end else begin
				page_size_q <= pwdata[8:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == REG_NACK_LIMIT[2]) begin
			prdata = {24'd0, nack_limit_q};
		end else begin
			prdata = {23'd0, page_size_q};
		end
	end

	// ---------------- handshake ----------------
	assign advance    = v_s1 && (!out_v_q || !result_stall);
	assign item_stall = v_s1 && out_v_q && result_stall;
	assign accept     = item_valid && !item_stall;

	// ---------------- next-state decision ----------------
	assign ps       = (page_size_q == 9'd0) ? 9'd1 : page_size_q;
	assign ps_pe    = PE_W'(ps);
	assign bp9      = 9'(buf_pos_q);
	assign bp_inc   = buf_pos_q + 1'b1;
	assign nack_inc = (nack_q == NACK_SAT) ? nack_q : nack_q + 8'd1;

	always_comb begin
		phase_d     = phase_q;
		is_write_d  = is_write_q;
		polling_d   = polling_q;
		restarted_d = restarted_q;
		hi_d        = hi_q;
		lo_d        = lo_q;
		fail_d      = fail_q;
		dev_d       = dev_q;
		maddr_d     = maddr_q;
		tx_fill_d   = tx_fill_q;
		buf_pos_d   = buf_pos_q;
		page_end_d  = page_end_q;
		rx_total_d  = rx_total_q;
		nack_d      = nack_q;
		res         = '0;
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		mem_sel     = 1'b0;
		mem_addr    = buf_pos_q[IDX_W-1:0];
		mem_wdata   = item.rx_byte;
		n9          = 9'(item.read_count);
		if (n9 == 9'd0) begin
			n9 = 9'd1;
		end
		if (n9 > BUF_LEN_9) begin
			n9 = BUF_LEN_9;
		end

		case (item.op)
			OP_LOAD: begin
				if (tx_fill_q == BUF_FULL) begin
					tx_fill_d  = '0;
					res.status = ST_FULL;
				end else if (phase_q != PH_IDLE) begin
					res.status = ST_BUSY;
				end else begin
					mem_we    = 1'b1;
					mem_addr  = tx_fill_q[IDX_W-1:0];
					mem_wdata = item.data_byte;
					tx_fill_d = tx_fill_q + 1'b1;
				end
			end
			OP_WRITE, OP_READ: begin
				if (phase_q != PH_IDLE) begin
					res.status = ST_BUSY;
				end else begin
					is_write_d  = (item.op == OP_WRITE);
					dev_d       = item.device_addr & DEV_ADDR_MASK;
					maddr_d     = item.mem_addr;
					buf_pos_d   = '0;
					restarted_d = 1'b0;
					hi_d        = 1'b0;
					lo_d        = 1'b0;
					phase_d     = PH_START;
					fail_d      = 1'b0;
					polling_d   = 1'b1;
					nack_d      = '0;
					res.bus_cmd = CMD_START;
					if (item.op == OP_WRITE) begin
						page_end_d = ps_pe;
					end else begin
						rx_total_d = n9[CNT_W-1:0];
					end
				end
			end
			default: begin
				if (phase_q != PH_IDLE) begin
					if (item.bus_collision) begin
						restarted_d = 1'b0;
						hi_d        = 1'b0;
						lo_d        = 1'b0;
						phase_d     = PH_START;
						res.bus_cmd = CMD_START;
					end else begin
						case (phase_q)
							PH_START: begin
								res.send_byte = dev_q;
								res.bus_cmd   = CMD_SEND;
								phase_d       = PH_ACKWAIT;
							end
							PH_RESTART: begin
								res.send_byte = dev_q | DEV_RD_BIT;
								res.bus_cmd   = CMD_SEND;
								phase_d       = PH_ACKWAIT;
							end
							PH_STOP: begin
								if (fail_q) begin
									res.failed = 1'b1;
								end else if (polling_q) begin
									res.bus_cmd = CMD_START;
								end else begin
									res.write_done = is_write_q;
									res.read_done  = !is_write_q;
								end
								if (!fail_q && polling_q) begin
									phase_d = PH_START;
								end else begin
									phase_d     = PH_IDLE;
									is_write_d  = 1'b0;
									polling_d   = 1'b0;
									restarted_d = 1'b0;
									hi_d        = 1'b0;
									lo_d        = 1'b0;
								end
							end
							PH_ACKWAIT: begin
								if (item.ack_stat) begin
									if (!polling_q) begin
										nack_d = nack_inc;
										if (nack_limit_q != 8'd0 && nack_inc >= nack_limit_q) begin
											fail_d = 1'b1;
										end
									end
									phase_d     = PH_STOP;
									res.bus_cmd = CMD_STOP;
								end else begin
									polling_d = 1'b0;
									if (hi_q && lo_q) begin
										if (is_write_q) begin
											if (buf_pos_q >= tx_fill_q) begin
												phase_d     = PH_STOP;
												res.bus_cmd = CMD_STOP;
												tx_fill_d   = '0;
											end else if (PE_W'(buf_pos_q) >= page_end_q) begin
												phase_d     = PH_STOP;
												res.bus_cmd = CMD_STOP;
												page_end_d  = page_end_q + ps_pe;
												polling_d   = 1'b1;
												maddr_d     = maddr_q + 16'(ps);
												hi_d        = 1'b0;
												lo_d        = 1'b0;
											end else begin
												mem_re      = 1'b1;
												mem_sel     = 1'b1;
												res.bus_cmd = CMD_SEND;
												buf_pos_d   = bp_inc;
											end
										end else if (restarted_q) begin
											res.bus_cmd = CMD_RECV;
											phase_d     = PH_RECV;
										end else begin
											res.bus_cmd = CMD_RESTART;
											phase_d     = PH_RESTART;
											restarted_d = 1'b1;
										end
									end else if (hi_q) begin
										res.send_byte = maddr_q[7:0];
										res.bus_cmd   = CMD_SEND;
										lo_d          = 1'b1;
									end else begin
										res.send_byte = maddr_q[15:8];
										res.bus_cmd   = CMD_SEND;
										hi_d          = 1'b1;
									end
								end
							end
							PH_RECV: begin
								// bytes past the buffer end are reported but not stored
								mem_we       = (buf_pos_q < BUF_FULL);
								res.rx_valid = 1'b1;
								res.rx_index = bp9[5:0];
								res.rx_data  = item.rx_byte;
								buf_pos_d    = bp_inc;
								if (bp_inc >= rx_total_q) begin
									res.bus_cmd = CMD_NACK;
									phase_d     = PH_NACKSENT;
								end else begin
									res.bus_cmd = CMD_ACK;
									phase_d     = PH_ACKSENT;
								end
							end
							PH_ACKSENT: begin
								res.bus_cmd = CMD_RECV;
								phase_d     = PH_RECV;
							end
							default: begin
								res.bus_cmd = CMD_STOP;
								phase_d     = PH_STOP;
							end
						endcase
					end
				end
			end
		endcase
	end

	// ---------------- sequencer state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			is_write_q  <= 1'b0;
			polling_q   <= 1'b0;
			restarted_q <= 1'b0;
			hi_q        <= 1'b0;
			lo_q        <= 1'b0;
			fail_q      <= 1'b0;
			dev_q       <= '0;
			maddr_q     <= '0;
			tx_fill_q   <= '0;
			buf_pos_q   <= '0;
			page_end_q  <= '0;
			rx_total_q  <= '0;
			nack_q      <= '0;
		end else if (accept) begin
			phase_q     <= phase_d;
			is_write_q  <= is_write_d;
			polling_q   <= polling_d;
			restarted_q <= restarted_d;
			hi_q        <= hi_d;
			lo_q        <= lo_d;
			fail_q      <= fail_d;
			dev_q       <= dev_d;
			maddr_q     <= maddr_d;
			tx_fill_q   <= tx_fill_d;
			buf_pos_q   <= buf_pos_d;
			page_end_q  <= page_end_d;
			rx_total_q  <= rx_total_d;
			nack_q      <= nack_d;
		end
	end

	// ---------------- byte buffer RAM ----------------
	always_ff @(posedge clk) begin
		if (accept && mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (accept && mem_re) begin
			rdata_q <= mem[mem_addr];
		end
	end

	// ---------------- RAM-read stage and output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (advance) begin
				v_s1 <= 1'b0;
			end
			if (advance) begin
				out_v_q <= 1'b1;
			end else if (!result_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_comb begin
		merged_s1 = res_s1;
		if (mem_sel_s1) begin
			merged_s1.send_byte = rdata_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1     <= res;
			mem_sel_s1 <= mem_sel;
		end
		if (advance) begin
			out_q <= merged_s1;
		end
	end

	assign result_valid = out_v_q;
	assign result       = out_q;

endmodule

// ----- sv/i2cem_chk.sv -----
// ----------------------------------------------------------------------------
// i2cem_chk
// Port-level checks for the I2C memory-device master sequencer.
// ----------------------------------------------------------------------------
module i2cem_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               item_stall,
	input logic               result_valid,
	input logic               result_stall,
	input i2cem_pkg::result_t result
);
	import i2cem_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result word changed");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("input stalled while output free");

	a_one_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |->
		$countones({result.write_done, result.read_done, result.failed}) <= 1)
		else $error("more than one completion flag");

	a_rx_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.rx_valid |->
		result.bus_cmd == CMD_ACK || result.bus_cmd == CMD_NACK)
		else $error("received byte without ack or nack");

	a_status_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status != ST_OK |-> result.bus_cmd == CMD_NONE)
		else $error("bus command issued on rejected word");

endmodule

bind i2c_eeprom_master_sequencer_core i2cem_chk u_i2cem_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives buffer loads, write/read requests and bus events into the I2C
// memory-device sequencer and checks every result word against a cycle-free
// software copy of the sequencer, with random idling and stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
	import i2cem_pkg::*;

	localparam int BUF_LEN = BUF_LEN_DEF;

	typedef enum logic [2:0] {
		SQ_IDLE, SQ_START, SQ_STOP, SQ_RESTART,
		SQ_ACKWAIT, SQ_RECV, SQ_ACKSENT, SQ_NACKSENT
	} seq_phase_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	item_t       item_w = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	result_t     result_w;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// sequencer shadow state
	seq_phase_e  phase_m = SQ_IDLE;
	logic        is_write_m = 1'b0;
	logic        polling_m = 1'b0;
	logic        restarted_m = 1'b0;
	logic        hi_sent_m = 1'b0;
	logic        lo_sent_m = 1'b0;
	logic        fail_m = 1'b0;
	logic [7:0]  dev_m = '0;
	logic [15:0] mem_m = '0;
	logic [6:0]  tx_fill_m = '0;
	logic [6:0]  buf_pos_m = '0;
	logic [7:0]  page_cnt_m = '0;
	logic [6:0]  rx_total_m = '0;
	logic [7:0]  nack_cnt_m = '0;
	logic [7:0]  buf_m [BUF_LEN];
	logic [8:0]  page_m = PAGE_SIZE_RST;
	logic [7:0]  limit_m = NACK_LIMIT_RST;

	item_t   pending_words [$];
	result_t expected_words [$];
	result_t want_w;
	int      pushed_cnt = 0;
	int      accepted_cnt = 0;
	int      useful_cnt = 0;
	int      out_cnt = 0;
	int      err_cnt = 0;
	int      tx_cyc = 0;
	int      rx_cyc = 0;
	int      hold_trig = 0;
	int      hold_seen = 0;
	int      hold_left = 0;

	i2c_eeprom_master_sequencer_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item_w),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result_w),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #10 clk = ~clk;

	function automatic result_t predict_sequencer(item_t w);
		result_t     r;
		int unsigned ps;
		int unsigned n;
		r = '0;
		case (w.op)
		OP_LOAD: begin
			if (tx_fill_m >= BUF_LEN) begin
				tx_fill_m = '0;
				r.status = ST_FULL;
			end else if (phase_m != SQ_IDLE) begin
				r.status = ST_BUSY;
			end else begin
				buf_m[tx_fill_m[5:0]] = w.data_byte;
				tx_fill_m++;
			end
		end
		OP_WRITE, OP_READ: begin
			if (phase_m != SQ_IDLE) begin
				r.status = ST_BUSY;
			end else begin
				is_write_m = (w.op == OP_WRITE);
				dev_m = w.device_addr & DEV_ADDR_MASK;
				mem_m = w.mem_addr;
				buf_pos_m = '0;
				restarted_m = 1'b0;
				hi_sent_m = 1'b0;
				lo_sent_m = 1'b0;
				phase_m = SQ_START;
				fail_m = 1'b0;
				polling_m = 1'b1;
				nack_cnt_m = '0;
				r.bus_cmd = CMD_START;
				if (is_write_m) begin
					page_cnt_m = 8'd1;
				end else begin
					n = 32'(w.read_count);
					if (n == 0) n = 1;
					if (n > BUF_LEN) n = BUF_LEN;
					rx_total_m = n[6:0];
				end
			end
		end
		OP_EVENT: begin
			if (phase_m != SQ_IDLE && w.bus_collision) begin
				restarted_m = 1'b0;
				hi_sent_m = 1'b0;
				lo_sent_m = 1'b0;
				phase_m = SQ_START;
				r.bus_cmd = CMD_START;
			end else if (phase_m != SQ_IDLE) begin
				case (phase_m)
				SQ_START: begin
					r.send_byte = dev_m;
					r.bus_cmd = CMD_SEND;
					phase_m = SQ_ACKWAIT;
				end
				SQ_RESTART: begin
					r.send_byte = dev_m | DEV_RD_BIT;
					r.bus_cmd = CMD_SEND;
					phase_m = SQ_ACKWAIT;
				end
				SQ_STOP: begin
					if (fail_m) begin
						r.failed = 1'b1;
					end else if (polling_m) begin
						phase_m = SQ_START;
						r.bus_cmd = CMD_START;
					end else begin
						r.write_done = is_write_m;
						r.read_done = !is_write_m;
					end
					if (r.bus_cmd != CMD_START) begin
						phase_m = SQ_IDLE;
						is_write_m = 1'b0;
						polling_m = 1'b0;
						restarted_m = 1'b0;
						hi_sent_m = 1'b0;
						lo_sent_m = 1'b0;
					end
				end
				SQ_ACKWAIT: begin
					if (w.ack_stat) begin
						if (!polling_m) begin
							if (nack_cnt_m != NACK_SAT) nack_cnt_m++;
							if (limit_m != 0 && nack_cnt_m >= limit_m) fail_m = 1'b1;
						end
						phase_m = SQ_STOP;
						r.bus_cmd = CMD_STOP;
					end else begin
						polling_m = 1'b0;
						if (hi_sent_m && lo_sent_m) begin
							if (is_write_m) begin
								ps = (page_m == 9'd0) ? 32'd1 : 32'(page_m);
								if (buf_pos_m >= tx_fill_m) begin
									phase_m = SQ_STOP;
									r.bus_cmd = CMD_STOP;
									tx_fill_m = '0;
								end else if (buf_pos_m >= page_cnt_m * ps) begin
									phase_m = SQ_STOP;
									r.bus_cmd = CMD_STOP;
									page_cnt_m++;
									polling_m = 1'b1;
									mem_m = mem_m + ps[15:0];
									hi_sent_m = 1'b0;
									lo_sent_m = 1'b0;
								end else begin
									r.send_byte = (buf_pos_m < BUF_LEN) ? buf_m[buf_pos_m[5:0]]
									                                    : 8'h00;
									r.bus_cmd = CMD_SEND;
									buf_pos_m++;
								end
							end else if (restarted_m) begin
								r.bus_cmd = CMD_RECV;
								phase_m = SQ_RECV;
							end else begin
								r.bus_cmd = CMD_RESTART;
								phase_m = SQ_RESTART;
								restarted_m = 1'b1;
							end
						end else if (hi_sent_m) begin
							r.send_byte = mem_m[7:0];
							r.bus_cmd = CMD_SEND;
							lo_sent_m = 1'b1;
						end else begin
							r.send_byte = mem_m[15:8];
							r.bus_cmd = CMD_SEND;
							hi_sent_m = 1'b1;
						end
					end
				end
				SQ_RECV: begin
					r.rx_data = w.rx_byte;
					if (buf_pos_m < BUF_LEN) buf_m[buf_pos_m[5:0]] = w.rx_byte;
					r.rx_valid = 1'b1;
					r.rx_index = buf_pos_m[5:0];
					buf_pos_m++;
					if (buf_pos_m >= rx_total_m) begin
						r.bus_cmd = CMD_NACK;
						phase_m = SQ_NACKSENT;
					end else begin
						r.bus_cmd = CMD_ACK;
						phase_m = SQ_ACKSENT;
					end
				end
				SQ_ACKSENT: begin
					r.bus_cmd = CMD_RECV;
					phase_m = SQ_RECV;
				end
				default: begin
					r.bus_cmd = CMD_STOP;
					phase_m = SQ_STOP;
				end
				endcase
			end
		end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string field, int got, int want);
		if (err_cnt < 100)
			$display("MISMATCH word %0d %s: got 0x%0h expected 0x%0h", out_cnt, field, got, want);
		err_cnt++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item_w <= '0;
		end else begin
			tx_cyc <= tx_cyc + 1;
			if (item_valid && !item_stall) begin
				if (item_w.op != OP_EVENT || phase_m != SQ_IDLE) useful_cnt++;
				expected_words.push_back(predict_sequencer(item_w));
				accepted_cnt++;
			end
			if (!item_valid || !item_stall) begin
				if (pending_words.size() != 0 &&
				    !((tx_cyc % 3000) >= 1000 && $urandom_range(0, 99) < 25)) begin
					item_valid <= 1'b1;
					item_w <= pending_words.pop_front();
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// monitor and result stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			rx_cyc <= rx_cyc + 1;
			if (result_valid && !result_stall) begin
				if (expected_words.size() == 0) begin
					report_mismatch("word with nothing expected, bus_cmd", result_w.bus_cmd, 0);
				end else begin
					want_w = expected_words.pop_front();
					if (result_w.status !== want_w.status)
						report_mismatch("status", result_w.status, want_w.status);
					if (result_w.bus_cmd !== want_w.bus_cmd)
						report_mismatch("bus_cmd", result_w.bus_cmd, want_w.bus_cmd);
					if (result_w.send_byte !== want_w.send_byte)
						report_mismatch("send_byte", result_w.send_byte, want_w.send_byte);
					if (result_w.rx_valid !== want_w.rx_valid)
						report_mismatch("rx_valid", result_w.rx_valid, want_w.rx_valid);
					if (result_w.rx_index !== want_w.rx_index)
						report_mismatch("rx_index", result_w.rx_index, want_w.rx_index);
					if (result_w.rx_data !== want_w.rx_data)
						report_mismatch("rx_data", result_w.rx_data, want_w.rx_data);
					if (result_w.write_done !== want_w.write_done)
						report_mismatch("write_done", result_w.write_done, want_w.write_done);
					if (result_w.read_done !== want_w.read_done)
						report_mismatch("read_done", result_w.read_done, want_w.read_done);
					if (result_w.failed !== want_w.failed)
						report_mismatch("failed", result_w.failed, want_w.failed);
				end
				out_cnt++;
			end
			if (hold_left != 0) begin
				result_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (hold_seen != hold_trig) begin
				hold_seen <= hold_trig;
				hold_left <= 80;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ((rx_cyc + 1500) % 3000) >= 1000 && $urandom_range(0, 99) < 25;
			end
		end
	end

	function automatic item_t rand_word();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[$bits(item_t)-1:0];
	endfunction

	task automatic queue_word(item_t w);
		pending_words.push_back(w);
		pushed_cnt++;
	endtask

	task automatic queue_load(logic [7:0] b);
		item_t w;
		w = rand_word();
		w.op = OP_LOAD;
		w.data_byte = b;
		queue_word(w);
	endtask

	task automatic queue_begin(logic [1:0] op, logic [7:0] dev, logic [15:0] mem,
	                           logic [6:0] cnt);
		item_t w;
		w = rand_word();
		w.op = op;
		w.device_addr = dev;
		w.mem_addr = mem;
		w.read_count = cnt;
		queue_word(w);
	endtask

	task automatic queue_event(logic nack, logic coll, logic [7:0] rx);
		item_t w;
		w = rand_word();
		w.op = OP_EVENT;
		w.ack_stat = nack;
		w.bus_collision = coll;
		w.rx_byte = rx;
		queue_word(w);
	endtask

	// feed bus events until the shadow sequencer is back to idle
	task automatic run_events(int nack_pct, int coll_pct);
		int n;
		while (accepted_cnt != pushed_cnt) @(negedge clk);
		while (phase_m != SQ_IDLE) begin
			n = $urandom_range(3, 10);
			repeat (n)
				queue_event($urandom_range(0, 99) < nack_pct,
				            $urandom_range(0, 99) < coll_pct, 8'($urandom));
			while (accepted_cnt != pushed_cnt) @(negedge clk);
		end
	endtask

	task automatic reg_write(logic [2:0] addr, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == REG_PAGE_SIZE) page_m = data[8:0];
		else if (addr == REG_NACK_LIMIT) limit_m = data[7:0];
	endtask

	initial begin
		int         ph;
		int         pick;
		int         target;
		int         nload;
		int         nack_pct;
		logic [6:0] cnt;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: idle event, busy load/request, collision, full write, short read
		queue_event(1'b1, 1'b1, 8'hff);
		queue_load(8'h00);
		queue_load(8'hff);
		queue_begin(OP_WRITE, 8'hff, 16'hffff, 7'd0);
		queue_load(8'h5a);
		queue_begin(OP_READ, 8'h01, 16'h0000, 7'd1);
		queue_event(1'b0, 1'b0, 8'h00);
		queue_event(1'b0, 1'b0, 8'h00);
		queue_event(1'b0, 1'b1, 8'h00);
		repeat (7) queue_event(1'b0, 1'b0, 8'($urandom));
		queue_begin(OP_READ, 8'h00, 16'h0000, 7'd0);
		repeat (6) queue_event(1'b0, 1'b0, 8'h00);
		queue_event(1'b0, 1'b0, 8'hff);
		repeat (2) queue_event(1'b0, 1'b0, 8'h00);
		run_events(0, 0);

		for (ph = 0; ph < 6; ph++) begin
			run_events(0, 0);
			while (expected_words.size() != 0) @(negedge clk);
			repeat (4) @(negedge clk);
			case (ph)
			1: begin reg_write(REG_PAGE_SIZE, 32'd1);   reg_write(REG_NACK_LIMIT, 32'd1);   end
			2: begin reg_write(REG_PAGE_SIZE, 32'd256); reg_write(REG_NACK_LIMIT, 32'd255); end
			3: begin reg_write(REG_PAGE_SIZE, 32'd0);   reg_write(REG_NACK_LIMIT, 32'd2);   end
			4: begin reg_write(REG_PAGE_SIZE, 32'd511); reg_write(REG_NACK_LIMIT, 32'd0);   end
			5: begin
				reg_write(REG_PAGE_SIZE, $urandom_range(2, 16));
				reg_write(REG_NACK_LIMIT, $urandom_range(0, 3));
			end
			default: ;
			endcase
			@(negedge clk);
			nack_pct = (limit_m == 1 || limit_m == 2) ? 25 : 10;

			// receiver holds off while a burst of loads keeps coming
			hold_trig++;
			repeat (30) queue_load(8'($urandom));
			while (accepted_cnt != pushed_cnt) @(negedge clk);

			target = useful_cnt + 50;
			while (useful_cnt < target) begin
				pick = $urandom_range(0, 99);
				if (pick < 45) begin
					nload = ($urandom_range(0, 99) < 10) ? $urandom_range(17, 64)
					                                     : $urandom_range(0, 10);
					repeat (nload) queue_load(8'($urandom));
					queue_begin(OP_WRITE, 8'($urandom), 16'($urandom), 7'($urandom));
					run_events(nack_pct, 5);
				end else if (pick < 80) begin
					pick = $urandom_range(0, 99);
					if (pick < 8) cnt = 7'd0;
					else if (pick < 16) cnt = 7'($urandom_range(65, 127));
					else if (pick < 22) cnt = 7'd64;
					else cnt = 7'($urandom_range(1, 6));
					queue_begin(OP_READ, 8'($urandom), 16'($urandom), cnt);
					run_events(nack_pct, 5);
				end else begin
					repeat ($urandom_range(1, 6)) queue_word(rand_word());
					while (accepted_cnt != pushed_cnt) @(negedge clk);
				end
			end
		end

		while (accepted_cnt != pushed_cnt || expected_words.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (err_cnt == 0 && expected_words.size() == 0) begin
			$display("i2c_eeprom_master_sequencer_core test passed");
		end else begin
			$display("i2c_eeprom_master_sequencer_core test failed");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("i2c_eeprom_master_sequencer_core test failed");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/i2cem_pkg.sv
sv/i2c_eeprom_master_sequencer_core.sv
sv/i2cem_chk.sv
bench/testbench.sv
